/* hw/rtl/mbe_pkg.sv */
// Shared constants, types and saturation helper for the escape-time block.
`timescale 1ns / 1ps
package mbe_pkg;

  localparam int COORD_BITS    = 32;
  localparam int FRAC          = COORD_BITS - 4;
  localparam int ITER_BITS     = 16;
  localparam int POS_BITS      = 12;
  localparam int DIM_BITS      = 13;
  localparam int MAX_DIM       = 4096;
  localparam int PROD_W        = POS_BITS + COORD_BITS;
  localparam int SUM_W         = COORD_BITS + 16;
  localparam int CFG_ADDR_BITS = 3;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [CFG_ADDR_BITS-1:0] CFG_ORIGIN_REAL = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_ORIGIN_IMAG = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_REAL_SPAN   = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_IMAG_SPAN   = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_FRAME_W     = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_FRAME_H     = 3'd5;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_ITER_LIMIT  = 3'd6;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] origin_real;
    logic signed [COORD_BITS-1:0] origin_imag;
    logic signed [COORD_BITS-1:0] real_span;
    logic signed [COORD_BITS-1:0] imag_span;
    logic [DIM_BITS-1:0]          frame_width;
    logic [DIM_BITS-1:0]          frame_height;
    logic [ITER_BITS-1:0]         iteration_limit;
  } mbe_cfg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] cr;
    logic signed [COORD_BITS-1:0] ci;
    logic                         frame_start;
  } mbe_point_t;

  // Clamp a wide signed sum to the coordinate range.
  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] hi_lim;
    logic signed [SUM_W-1:0] lo_lim;
    hi_lim = {{(SUM_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    lo_lim = ~hi_lim;
    if (v > hi_lim) return hi_lim[COORD_BITS-1:0];
    if (v < lo_lim) return lo_lim[COORD_BITS-1:0];
    return v[COORD_BITS-1:0];
  endfunction

endpackage

/* hw/rtl/mbe_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module mbe_div import mbe_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [PROD_W-1:0]   dividend,
  input  logic [DIM_BITS-1:0] divisor,
  output logic [PROD_W-1:0]   quotient,
  output logic                busy
);
  localparam int CNT_W = $clog2(PROD_W + 1);

  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [PROD_W-1:0]   quo_r, quo_nxt;
  logic [DIM_BITS-1:0] rem_r, rem_nxt;
  logic [DIM_BITS:0]   rem_sh;
  logic [DIM_BITS:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem_r, quo_r[PROD_W-1]};
    rem_sub = rem_sh - {1'b0, divisor};
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    if (start) begin
      cnt_nxt = CNT_W'(PROD_W);
      quo_nxt = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (rem_sh >= {1'b0, divisor}) begin
        rem_nxt = rem_sub[DIM_BITS-1:0];
        quo_nxt = {quo_r[PROD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DIM_BITS-1:0];
        quo_nxt = {quo_r[PROD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient = quo_r;
  assign busy     = (cnt_r != '0);
endmodule

/* hw/rtl/mbe_front.sv */
// Front end: accept pixel, map it to a complex point, hand it to the queue.
`timescale 1ns / 1ps
module mbe_front import mbe_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  mbe_cfg_t            cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [POS_BITS-1:0] column,
  input  logic [POS_BITS-1:0] row,
  input  logic                frame_start,
  output logic                push,
  output mbe_point_t          point,
  input  logic                full
);
  localparam logic [1:0] F_IDLE  = 2'd0;
  localparam logic [1:0] F_START = 2'd1;
  localparam logic [1:0] F_DIV   = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [PROD_W-1:0]       mag_re_r, mag_im_r;
  logic                    neg_re_r, neg_im_r, fs_r;
  logic signed [PROD_W:0]  prod_re, prod_im;
  logic signed [PROD_W:0]  abs_re, abs_im;
  logic [PROD_W-1:0]       quo_re, quo_im;
  logic                    busy_re, busy_im, start;
  logic signed [SUM_W-1:0] q_re, q_im, sum_re, sum_im;

  assign prod_re = $signed({1'b0, column}) * cfg.real_span;
  assign prod_im = $signed({1'b0, row}) * cfg.imag_span;
  assign abs_re  = prod_re[PROD_W] ? -prod_re : prod_re;
  assign abs_im  = prod_im[PROD_W] ? -prod_im : prod_im;

  assign in_ready = (state_r == F_IDLE);
  assign start    = (state_r == F_START);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mag_re_r <= abs_re[PROD_W-1:0];
      mag_im_r <= abs_im[PROD_W-1:0];
      neg_re_r <= prod_re[PROD_W];
      neg_im_r <= prod_im[PROD_W];
      fs_r     <= frame_start;
    end
  end

  mbe_div u_div_re (
    .clk(clk), .rst_n(rst_n), .start(start), .dividend(mag_re_r),
    .divisor(cfg.frame_width), .quotient(quo_re), .busy(busy_re)
  );
  mbe_div u_div_im (
    .clk(clk), .rst_n(rst_n), .start(start), .dividend(mag_im_r),
    .divisor(cfg.frame_height), .quotient(quo_im), .busy(busy_im)
  );

  // Quotient truncates toward zero: apply the sign after dividing magnitudes.
  always_comb begin
    q_re   = $signed({{(SUM_W-PROD_W){1'b0}}, quo_re});
    q_im   = $signed({{(SUM_W-PROD_W){1'b0}}, quo_im});
    if (neg_re_r) q_re = -q_re;
    if (neg_im_r) q_im = -q_im;
    sum_re = q_re + {{(SUM_W-COORD_BITS){cfg.origin_real[COORD_BITS-1]}}, cfg.origin_real};
    sum_im = q_im + {{(SUM_W-COORD_BITS){cfg.origin_imag[COORD_BITS-1]}}, cfg.origin_imag};
    point.cr          = sat_coord(sum_re);
    point.ci          = sat_coord(sum_im);
    point.frame_start = fs_r;
  end

  assign push = (state_r == F_DIV) && !busy_re && !busy_im && !full;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (in_valid) state_nxt = F_START;
      F_START: state_nxt = F_DIV;
      F_DIV:   if (push) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

/* hw/rtl/mbe_fifo.sv */
// Short register queue between front and back.
`timescale 1ns / 1ps
module mbe_fifo import mbe_pkg::*; #(
  parameter int WIDTH = $bits(mbe_point_t),
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ptr_inc(wp_r);
      if (pop)  rp_r <= ptr_inc(rp_r);
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
    if (push) mem_r[wp_r] <= wdata;
  end

  assign rdata = mem_r[rp_r];
  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
endmodule

/* hw/rtl/mbe_back.sv */
// Back end: escape-time iteration, running extremes and output register.
`timescale 1ns / 1ps
module mbe_back import mbe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [ITER_BITS-1:0] iteration_limit,
  input  logic                 empty,
  input  mbe_point_t           point,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ITER_BITS-1:0] iterations,
  output logic [ITER_BITS-1:0] fewest_seen,
  output logic [ITER_BITS-1:0] most_seen
);
  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MUL  = 2'd1;
  localparam logic [1:0] B_ADD  = 2'd2;
  localparam logic [1:0] B_DONE = 2'd3;
  localparam int         PW     = 2 * COORD_BITS;
  localparam logic [PW:0] FOUR  = (PW+1)'(1) << (2 * FRAC + 2);

  logic [1:0]                   state_r, state_nxt;
  logic signed [COORD_BITS-1:0] zr_r, zi_r, cr_r, ci_r;
  logic                         fs_r;
  logic [ITER_BITS-1:0]         n_r;
  logic signed [PW-1:0]         rr_r, ii_r, ri_r;
  logic [PW:0]                  mag_sum;
  logic signed [PW:0]           diff, diff_sh;
  logic signed [PW-1:0]         ri_sh;
  logic signed [SUM_W-1:0]      nr_sum, ni_sum;
  logic                         escape, take;
  logic [ITER_BITS-1:0]         fewest_r, most_r, fewest_base, most_base;
  logic [ITER_BITS-1:0]         iter_out_r, fewest_out_r, most_out_r;
  logic                         out_valid_r;

  assign mag_sum = {1'b0, rr_r} + {1'b0, ii_r};
  assign escape  = mag_sum > FOUR;
  assign diff    = {rr_r[PW-1], rr_r} - {ii_r[PW-1], ii_r};
  assign diff_sh = diff >>> FRAC;
  assign ri_sh   = ri_r >>> (FRAC - 1);
  assign nr_sum  = diff_sh[SUM_W-1:0]
                 + {{(SUM_W-COORD_BITS){cr_r[COORD_BITS-1]}}, cr_r};
  assign ni_sum  = ri_sh[SUM_W-1:0]
                 + {{(SUM_W-COORD_BITS){ci_r[COORD_BITS-1]}}, ci_r};

  assign pop  = (state_r == B_IDLE) && !empty;
  assign take = (state_r == B_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (!empty) state_nxt = B_MUL;
      B_MUL:  state_nxt = (n_r == iteration_limit) ? B_DONE : B_ADD;
      B_ADD:  state_nxt = escape ? B_DONE : B_MUL;
      B_DONE: if (take) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // A frame start restarts the extremes before this pixel counts.
  assign fewest_base = fs_r ? {ITER_BITS{1'b1}} : fewest_r;
  assign most_base   = fs_r ? '0 : most_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      fewest_r    <= {ITER_BITS{1'b1}};
      most_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (take) begin
        out_valid_r <= 1'b1;
        fewest_r    <= (n_r < fewest_base) ? n_r : fewest_base;
        most_r      <= (n_r > most_base) ? n_r : most_base;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (pop) begin
      zr_r <= point.cr;
      zi_r <= point.ci;
      cr_r <= point.cr;
      ci_r <= point.ci;
      fs_r <= point.frame_start;
      n_r  <= '0;
    end
    if (state_r == B_MUL) begin
      rr_r <= zr_r * zr_r;
      ii_r <= zi_r * zi_r;
      ri_r <= zr_r * zi_r;
    end
    if (state_r == B_ADD && !escape) begin
      zr_r <= sat_coord(nr_sum);
      zi_r <= sat_coord(ni_sum);
      n_r  <= n_r + 1'b1;
    end
    if (take) begin
      iter_out_r   <= n_r;
      fewest_out_r <= (n_r < fewest_base) ? n_r : fewest_base;
      most_out_r   <= (n_r > most_base) ? n_r : most_base;
    end
  end

  assign out_valid   = out_valid_r;
  assign iterations  = iter_out_r;
  assign fewest_seen = fewest_out_r;
  assign most_seen   = most_out_r;

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_MUL || state_r == B_ADD) |-> n_r <= iteration_limit)
    else $error("iteration count beyond limit");

  a_extremes_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> fewest_out_r <= most_out_r)
    else $error("fewest exceeds most");

  a_add_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_ADD) |-> $past(state_r) == B_MUL)
    else $error("add step without products");

  a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> iter_out_r <= iteration_limit)
    else $error("result beyond limit");
endmodule

/* hw/rtl/mandelbrot_escape_time.sv */
// Top level of the Mandelbrot escape-time pixel evaluator.
`timescale 1ns / 1ps
// Each transaction on the input stream carries one pixel position; the block maps it to
// c = origin + position*span/size in signed Q4.28, iterates z = z^2 + c from z = c until
// |z|^2 exceeds 4 or iteration_limit is reached, and returns one transaction with the
// count and the fewest and most counts seen since the last frame_start. The front end
// takes a pixel, forms position*span and runs two bit-serial dividers, and accepts no new
// pixel until both quotients have gone into the queue. The back end takes the point, then
// per iteration forms the three 32x32 products in a multiply state and makes the escape
// test and update in an add state, until the point escapes or the limit is reached; a
// done state registers the result and holds while an earlier result waits on the output.
// A two-entry queue sits between the halves; sustained throughput is the slower of the
// two. Configuration writes are taken at any time but must only be issued while the
// block is idle. Writes of zero to sizes or the limit store one; sizes clamp to 4096.
module mandelbrot_escape_time import mbe_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [23:0]              in_tdata,   // column[11:0], row[23:12]
  input  logic                     in_tuser,   // frame_start
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [47:0]              out_tdata,  // iterations, fewest_seen, most_seen
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [COORD_BITS-1:0]    cfg_wdata
);
  mbe_cfg_t             cfg_r;
  logic [DIM_BITS-1:0]  size_w;
  logic [ITER_BITS-1:0] limit_w;
  logic                 push, pop, full, empty;
  mbe_point_t           push_pt, pop_pt;
  logic [ITER_BITS-1:0] iterations, fewest_seen, most_seen;

  // Zero becomes one; oversize frames clamp to the largest supported dimension.
  always_comb begin
    size_w = cfg_wdata[DIM_BITS-1:0];
    if (size_w == '0) size_w = DIM_BITS'(1);
    else if (size_w > DIM_BITS'(MAX_DIM)) size_w = DIM_BITS'(MAX_DIM);
    limit_w = cfg_wdata[ITER_BITS-1:0];
    if (limit_w == '0) limit_w = ITER_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_real     <= 32'shE000_0000;
      cfg_r.origin_imag     <= 32'shF000_0000;
      cfg_r.real_span       <= 32'sh3000_0000;
      cfg_r.imag_span       <= 32'sh2000_0000;
      cfg_r.frame_width     <= DIM_BITS'(640);
      cfg_r.frame_height    <= DIM_BITS'(480);
      cfg_r.iteration_limit <= ITER_BITS'(256);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ORIGIN_REAL: cfg_r.origin_real     <= cfg_wdata;
        CFG_ORIGIN_IMAG: cfg_r.origin_imag     <= cfg_wdata;
        CFG_REAL_SPAN:   cfg_r.real_span       <= cfg_wdata;
        CFG_IMAG_SPAN:   cfg_r.imag_span       <= cfg_wdata;
        CFG_FRAME_W:     cfg_r.frame_width     <= size_w;
        CFG_FRAME_H:     cfg_r.frame_height    <= size_w;
        CFG_ITER_LIMIT:  cfg_r.iteration_limit <= limit_w;
        default: ; // drop writes to unknown registers
      endcase
    end
  end

  mbe_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .column(in_tdata[11:0]), .row(in_tdata[23:12]), .frame_start(in_tuser),
    .push(push), .point(push_pt), .full(full)
  );

  mbe_fifo #(.WIDTH($bits(mbe_point_t)), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .wdata(push_pt), .full(full),
    .pop(pop), .rdata(pop_pt), .empty(empty)
  );

  mbe_back u_back (
    .clk(clk), .rst_n(rst_n), .iteration_limit(cfg_r.iteration_limit),
    .empty(empty), .point(pop_pt), .pop(pop),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .iterations(iterations), .fewest_seen(fewest_seen), .most_seen(most_seen)
  );

  assign out_tdata = {most_seen, fewest_seen, iterations};
endmodule

/* tb/tb_mandelbrot_escape_time.sv */
// Self-checking testbench for the Mandelbrot escape-time pixel evaluator.
`timescale 1ns / 1ps
module tb_mandelbrot_escape_time;
  import mbe_pkg::*;

  // Index 7 is not decoded by the block; a write there must change nothing.
  localparam logic [CFG_ADDR_BITS-1:0] CFG_UNDECODED = 3'd7;
  localparam int STALL_LIMIT = 400000;
  localparam int HOLD_CYCLES = 600;
  localparam int NO_TYPED    = -1;
  localparam logic signed [67:0] ESCAPE_RADIUS_SQ = 68'sd1 <<< (2 * FRAC + 2);

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [23:0]              in_tdata;   // column[11:0], row[23:12]
  logic                     in_tuser;   // frame_start
  logic                     out_tvalid;
  logic                     out_tready;
  logic [47:0]              out_tdata;  // iterations[15:0], fewest_seen[31:16], most_seen[47:32]
  logic                     cfg_we;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [COORD_BITS-1:0]    cfg_wdata;

  mandelbrot_escape_time dut (.*);

  typedef struct {
    logic [15:0] iterations;
    logic [15:0] fewest;
    logic [15:0] most;
    int          typed_iterations;  // hand-written value, or NO_TYPED
  } count_t;

  typedef struct {
    int col;
    int row;
    bit start;
    int typed_iterations;
  } pixel_row_t;

  // Mirror of the block's registers and running extremes.
  logic signed [31:0] m_origin_re, m_origin_im, m_span_re, m_span_im;
  int                 m_width, m_rows, m_limit;
  logic [15:0]        m_fewest, m_most;

  count_t counts_due[$];
  int     pending_typed;
  int     n_errors;
  int     n_offered, n_taken;
  bit     hold_req;
  bit     burst_mode;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp_coord(input logic signed [67:0] v);
    if (v > 68'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -68'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Map a pixel position onto the complex plane; division truncates toward zero.
  function automatic logic signed [31:0] plane_coord(input logic signed [31:0] origin,
                                                    input logic signed [31:0] span,
                                                    input int pos, input int size);
    longint prod;
    prod = longint'(pos) * longint'(span);
    return clamp_coord(68'(longint'(origin) + prod / longint'(size)));
  endfunction

  function automatic int escape_iterations(input logic signed [31:0] cr,
                                           input logic signed [31:0] ci);
    logic signed [31:0] zr, zi;
    logic signed [67:0] rr, ii, ri;
    int n;
    zr = cr;
    zi = ci;
    n  = 0;
    while (n < m_limit) begin
      rr = zr * zr;
      ii = zi * zi;
      if (rr + ii > ESCAPE_RADIUS_SQ) break;
      ri = zr * zi;
      // Arithmetic shifts floor, as the block does.
      zr = clamp_coord(((rr - ii) >>> FRAC) + cr);
      zi = clamp_coord((ri >>> (FRAC - 1)) + ci);
      n++;
    end
    return n;
  endfunction

  function automatic count_t predict_count(input int col, input int row, input bit start);
    count_t r;
    int n;
    n = escape_iterations(plane_coord(m_origin_re, m_span_re, col, m_width),
                          plane_coord(m_origin_im, m_span_im, row, m_rows));
    if (start) begin
      m_fewest = 16'hFFFF;
      m_most   = 16'h0000;
    end
    if (n < m_fewest) m_fewest = n[15:0];
    if (n > m_most) m_most = n[15:0];
    r.iterations = n[15:0];
    r.fewest = m_fewest;
    r.most = m_most;
    r.typed_iterations = NO_TYPED;
    return r;
  endfunction

  function automatic int size_stored(input logic [31:0] v);
    if (v[12:0] == 13'd0) return 1;
    if (v[12:0] > MAX_DIM) return MAX_DIM;
    return int'(v[12:0]);
  endfunction

  // Call at a falling edge; leaves cfg_we high, the caller lowers it.
  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ORIGIN_REAL: m_origin_re = val;
      CFG_ORIGIN_IMAG: m_origin_im = val;
      CFG_REAL_SPAN:   m_span_re = val;
      CFG_IMAG_SPAN:   m_span_im = val;
      CFG_FRAME_W:     m_width = size_stored(val);
      CFG_FRAME_H:     m_rows = size_stored(val);
      CFG_ITER_LIMIT:  m_limit = (val[15:0] == 16'd0) ? 1 : int'(val[15:0]);
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Drain the block, then load a whole new view of the plane.
  task automatic load_view(input logic [31:0] ore, input logic [31:0] oim,
                           input logic [31:0] sre, input logic [31:0] sim,
                           input logic [31:0] w, input logic [31:0] h,
                           input logic [31:0] lim);
    while (counts_due.size() != 0 || n_offered != n_taken) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
    write_reg(CFG_ORIGIN_REAL, ore);
    write_reg(CFG_ORIGIN_IMAG, oim);
    write_reg(CFG_REAL_SPAN, sre);
    write_reg(CFG_IMAG_SPAN, sim);
    write_reg(CFG_FRAME_W, w);
    write_reg(CFG_FRAME_H, h);
    write_reg(CFG_ITER_LIMIT, lim);
    write_reg(CFG_UNDECODED, $urandom);
    cfg_we <= 1'b0;
  endtask

  // Offer one pixel; called at a falling edge, returns at a falling edge after acceptance.
  task automatic send_pixel(input int col, input int row, input bit start, input int typed);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {row[11:0], col[11:0]};
    in_tuser  <= start;
    pending_typed = typed;
    n_offered++;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic random_pixels(input int count);
    int col, row;
    repeat (count) begin
      if ($urandom_range(0, 49) == 0) burst_mode = ~burst_mode;
      if ($urandom_range(0, 9) == 0) begin
        // Off-frame positions are extrapolated, not rejected.
        col = $urandom_range(0, 4095);
        row = $urandom_range(0, 4095);
      end else begin
        col = $urandom_range(0, (m_width > 4096 ? 4096 : m_width) - 1);
        row = $urandom_range(0, m_rows - 1);
      end
      send_pixel(col, row, $urandom_range(0, 19) == 0, NO_TYPED);
    end
  endtask

  // Directed pixels in the reset view: -2-1i, span 3+2i, 640x480, limit 256.
  pixel_row_t directed[12] = '{
    '{0,    0,    1'b1, 0},    // corner outside the set
    '{4095, 4095, 1'b0, 0},    // farthest position, far outside
    '{320,  240,  1'b0, 256},  // c = -0.5, inside the cardioid
    '{0,    240,  1'b0, NO_TYPED},  // c = -2, orbit sits on the radius
    '{427,  240,  1'b0, NO_TYPED},
    '{639,  479,  1'b1, NO_TYPED},  // last in-frame pixel after a new frame
    '{640,  480,  1'b0, NO_TYPED},  // just beyond the frame
    '{500,  380,  1'b0, NO_TYPED},
    '{300,  360,  1'b0, NO_TYPED},
    '{2730, 1365, 1'b0, NO_TYPED},
    '{1365, 2730, 1'b1, NO_TYPED},
    '{200,  100,  1'b0, NO_TYPED}
  };

  // Receiver: random gaps, bursts of continuous readiness and one long hold.
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      gap = burst_mode ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Predict on input transactions, compare on output transactions.
  always @(posedge clk) begin
    count_t got, want;
    if (rst_n && in_tvalid && in_tready) begin
      want = predict_count(in_tdata[11:0], in_tdata[23:12], in_tuser);
      want.typed_iterations = pending_typed;
      counts_due.push_back(want);
      n_taken++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.iterations = out_tdata[15:0];
      got.fewest     = out_tdata[31:16];
      got.most       = out_tdata[47:32];
      if (counts_due.size() == 0) begin
        $error("unexpected result transaction %h", out_tdata);
        n_errors++;
      end else begin
        want = counts_due.pop_front();
        if (got.iterations != want.iterations) begin
          $error("iterations: expected %0d, got %0d", want.iterations, got.iterations);
          n_errors++;
        end
        if (want.typed_iterations != NO_TYPED && got.iterations != want.typed_iterations) begin
          $error("iterations: expected %0d, got %0d", want.typed_iterations, got.iterations);
          n_errors++;
        end
        if (got.fewest != want.fewest) begin
          $error("fewest_seen: expected %0d, got %0d", want.fewest, got.fewest);
          n_errors++;
        end
        if (got.most != want.most) begin
          $error("most_seen: expected %0d, got %0d", want.most, got.most);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: give up after a long stretch with no transaction on either stream.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
      if (idle >= STALL_LIMIT) begin
        $display("tb_mandelbrot_escape_time: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    n_errors = 0;
    n_offered = 0;
    n_taken = 0;
    hold_req = 1'b0;
    burst_mode = 1'b0;
    pending_typed = NO_TYPED;
    // Reset view of the plane.
    m_origin_re = -32'sd536870912;
    m_origin_im = -32'sd268435456;
    m_span_re = 32'sd805306368;
    m_span_im = 32'sd536870912;
    m_width = 640;
    m_rows = 480;
    m_limit = 256;
    m_fewest = 16'hFFFF;
    m_most = 16'h0000;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i])
      send_pixel(directed[i].col, directed[i].row, directed[i].start,
                 directed[i].typed_iterations);
    in_tvalid <= 1'b0;

    // Whole set at small size, with the receiver holding off early on.
    load_view(-32'sd536870912, -32'sd335544320, 32'sd671088640, 32'sd671088640,
              32'd64, 32'd64, 32'd64);
    hold_req = 1'b1;
    random_pixels(300);
    in_tvalid <= 1'b0;

    // Extremes: zero width and limit, oversize height, extreme origins and spans.
    load_view(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'd0, 32'h1FFF, 32'd0);
    random_pixels(60);
    in_tvalid <= 1'b0;

    // Zoom near the boundary on a wide single-row frame.
    load_view(-32'sd201326592, 32'sd174483456, 32'sd13421772, 32'sd13421772,
              32'd4096, 32'd1, 32'd300);
    random_pixels(200);
    in_tvalid <= 1'b0;

    // Negative spans, oversize width field, small limit.
    load_view(32'sd268435456, 32'sd402653184, -32'sd805306368, -32'sd805306368,
              32'h1001, 32'd4095, 32'd16);
    random_pixels(220);
    in_tvalid <= 1'b0;

    // Largest limit: the origin sits inside the set and runs to the limit.
    load_view(32'sd0, 32'sd0, 32'sd0, 32'sd268435456, 32'd1, 32'd8, 32'hFFFF);
    send_pixel(0, 0, 1'b1, 65535);
    send_pixel(5, 4095, 1'b0, NO_TYPED);
    in_tvalid <= 1'b0;

    while (counts_due.size() != 0 || n_offered != n_taken) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb_mandelbrot_escape_time: clean");
    end else begin
      $display("tb_mandelbrot_escape_time: errors");
    end
    $finish;
  end

endmodule
